// ===== sv/lru_ts_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_ts_pkg
// Shared types, sizes and helpers for the LRU tag store.
// ----------------------------------------------------------------------------
package lru_ts_pkg;

  // store geometry
  localparam int ENTRIES   = 4;
  localparam int KEY_WIDTH = 32;

  // width of the lookup_key and evicted_key fields
  localparam int KEY_FIELD_W = 32;
  // width of the slot field
  localparam int SLOT_FIELD_W = 2;

  // stored tag width: the key field never carries more than 32 bits
  localparam int TAG_W  = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = SLOT_W;

  // rank held by the least recent entry of a full store
  localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(ENTRIES - 1);
  localparam logic [RANK_W-1:0] RANK_NEWEST = '0;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [SLOT_W-1:0]  slot_idx_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [ENTRIES-1:0] entry_vec_t;

  typedef struct packed {
    op_t                    operation;
    logic [KEY_FIELD_W-1:0] lookup_key;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    fresh_value;
    logic                    evicted;
    logic [KEY_FIELD_W-1:0]  evicted_key;
  } out_item_t;

  // index of the lowest set bit, zero when none is set
  function automatic slot_idx_t first_set(entry_vec_t vec);
    slot_idx_t idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  // slot index as carried in the result field
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(slot_idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_FIELD_W-1:0];
  endfunction

  // stored tag widened to the key field
  function automatic logic [KEY_FIELD_W-1:0] key_field(tag_t tag);
    return KEY_FIELD_W'(tag);
  endfunction

endpackage

// ===== sv/lru_tag_store.sv =====
// ----------------------------------------------------------------------------
// lru_tag_store
// Fully associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//   channel | ports                        | beat carries
//   --------+------------------------------+-----------------------------------
//   input   | in_valid, in_ready, in_data  | operation, lookup_key
//   result  | out_valid, out_ready, out_data| hit, slot, fresh_value, evicted,
//           |                              | evicted_key
//
// one beat in, one beat out; a new beat can be taken every cycle unless the result is stalled
// a beat passes through the input register, then the result register
// tag compare, rank update and victim pick all sit in the single stage
// between those two registers, so the state is ready for the next beat
// reset (rst_n low, synchronous) empties the store and both registers
// a stalled result holds the stage behind it; in_ready then drops once the input register holds a beat
//
module lru_tag_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lru_ts_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lru_ts_pkg::out_item_t out_data
);

  // input register
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  lru_ts_pkg::in_item_t s1_data_r;

  // result register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  lru_ts_pkg::out_item_t out_data_r;
  lru_ts_pkg::out_item_t out_data_nxt;

  // store state
  lru_ts_pkg::entry_vec_t valid_r;
  lru_ts_pkg::entry_vec_t valid_nxt;
  lru_ts_pkg::rank_t      rank_r   [lru_ts_pkg::ENTRIES];
  lru_ts_pkg::rank_t      rank_nxt [lru_ts_pkg::ENTRIES];
  lru_ts_pkg::tag_t       tag_r    [lru_ts_pkg::ENTRIES];
  lru_ts_pkg::tag_t       tag_nxt  [lru_ts_pkg::ENTRIES];

  // lookup stage
  logic                   s1_adv;
  logic                   is_clear;
  lru_ts_pkg::tag_t       key_tag;
  lru_ts_pkg::entry_vec_t match_vec;
  lru_ts_pkg::entry_vec_t free_vec;
  lru_ts_pkg::entry_vec_t oldest_vec;
  logic                   is_hit;
  logic                   is_full;
  lru_ts_pkg::slot_idx_t  hit_idx;
  lru_ts_pkg::slot_idx_t  free_idx;
  lru_ts_pkg::slot_idx_t  vic_idx;
  lru_ts_pkg::slot_idx_t  tgt_idx;
  lru_ts_pkg::rank_t      hit_rank;

  // the lookup stage moves on when the result register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_clear = (s1_data_r.operation == lru_ts_pkg::OP_CLEAR);
  // upper key bits beyond the tag width are ignored
  assign key_tag  = s1_data_r.lookup_key[lru_ts_pkg::TAG_W-1:0];

  // per-entry compares, all in parallel
  always_comb begin
    for (int i = 0; i < lru_ts_pkg::ENTRIES; i++) begin
      match_vec[i]  = valid_r[i] && (tag_r[i] == key_tag);
      free_vec[i]   = !valid_r[i];
      // ranks of a full store form a permutation, so the oldest is unique
      oldest_vec[i] = (rank_r[i] == lru_ts_pkg::RANK_OLDEST);
    end
  end

  assign is_hit   = |match_vec;
  assign is_full  = &valid_r;
  assign hit_idx  = lru_ts_pkg::first_set(match_vec);
  assign free_idx = lru_ts_pkg::first_set(free_vec);
  assign vic_idx  = lru_ts_pkg::first_set(oldest_vec);
  assign hit_rank = rank_r[hit_idx];

  // slot that ends up holding the key: matching one, else victim or lowest free
  always_comb begin
    priority if (is_hit) begin
      tgt_idx = hit_idx;
    end else if (is_full) begin
      tgt_idx = vic_idx;
    end else begin
      tgt_idx = free_idx;
    end
  end

  // next store state
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < lru_ts_pkg::ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      tag_nxt[i]  = tag_r[i];
    end
    if (s1_adv) begin
      if (is_clear) begin
        valid_nxt = '0;
        for (int i = 0; i < lru_ts_pkg::ENTRIES; i++) begin
          rank_nxt[i] = lru_ts_pkg::RANK_NEWEST;
        end
      end else begin
        valid_nxt[tgt_idx] = 1'b1;
        for (int i = 0; i < lru_ts_pkg::ENTRIES; i++) begin
          if (tgt_idx == lru_ts_pkg::SLOT_W'(i)) begin
            rank_nxt[i] = lru_ts_pkg::RANK_NEWEST;
            // a miss writes its key into the chosen slot
            if (!is_hit) begin
              tag_nxt[i] = key_tag;
            end
          end else if (valid_r[i] && (!is_hit || (rank_r[i] < hit_rank))) begin
            // on a hit only the entries newer than the hit one age
            rank_nxt[i] = rank_r[i] + lru_ts_pkg::RANK_W'(1);
          end
        end
      end
    end
  end

  // result beat
  always_comb begin
    out_data_nxt = '0;
    if (!is_clear) begin
      out_data_nxt.slot = lru_ts_pkg::slot_field(tgt_idx);
      if (is_hit) begin
        out_data_nxt.hit = 1'b1;
      end else begin
        out_data_nxt.fresh_value = 1'b1;
        if (is_full) begin
          out_data_nxt.evicted     = 1'b1;
          out_data_nxt.evicted_key = lru_ts_pkg::key_field(tag_r[vic_idx]);
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      for (int i = 0; i < lru_ts_pkg::ENTRIES; i++) begin
        rank_r[i] <= lru_ts_pkg::RANK_NEWEST;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      for (int i = 0; i < lru_ts_pkg::ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
    for (int i = 0; i < lru_ts_pkg::ENTRIES; i++) begin
      tag_r[i] <= tag_nxt[i];
    end
  end

  // a clear beat leaves the store empty
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && is_clear) |=> (valid_r == '0))
    else $error("store not empty after clear");

  // a lookup always leaves at least one entry valid
  a_lookup_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !is_clear) |=> (valid_r != '0))
    else $error("store empty after lookup");

  // an eviction only happens on a miss that installs a fresh entry
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.evicted) |-> (out_data_r.fresh_value && !out_data_r.hit))
    else $error("eviction reported without a fresh miss");

endmodule
